### src/lhm_pkg.sv
// ----------------------------------------------------------------------------
// lhm_pkg
// Shared types, constants and helpers of the log2 latency histogram monitor.
// ----------------------------------------------------------------------------
package lhm_pkg;

  localparam int NUM_BINS = 64;
  localparam int BIN_AW   = 6;
  localparam int P95      = 95;
  localparam int P99      = 99;

  // Command codes carried on in_tuser.
  localparam logic CMD_RECORD   = 1'b0;
  localparam logic CMD_SNAPSHOT = 1'b1;

  // Per-channel counters, one stats memory word.
  typedef struct packed {
    logic [63:0] maxv;
    logic [63:0] total;
    logic [63:0] count;
  } stat_t;

  // Control from the sequencer to the percentile unit.
  typedef struct packed {
    logic              start;    // stats read data valid, open a new walk
    logic              bin_vld;  // bin read data valid this cycle
    logic [BIN_AW-1:0] bin_idx;  // bin the read data belongs to
  } pct_ctl_t;

  // Index of the highest set bit; zero maps to bin 0.
  function automatic logic [BIN_AW-1:0] bin_of(input logic [63:0] v);
    logic [BIN_AW-1:0] b;
    b = '0;
    for (int i = 1; i < NUM_BINS; i++) begin
      if (v[i]) begin
        b = BIN_AW'(i);
      end
    end
    return b;
  endfunction

  // Upper bound 2^(b+1)-1 of a bin; bin 63 gives all ones.
  function automatic logic [63:0] bin_upper(input logic [BIN_AW-1:0] b);
    return {64{1'b1}} >> (BIN_AW'(NUM_BINS - 1) - b);
  endfunction

endpackage

### src/lhm_ram.sv
// ----------------------------------------------------------------------------
// lhm_ram
// Simple dual-port synchronous RAM, read-first, registered read data.
// ----------------------------------------------------------------------------
module lhm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];   // old data on a same-address write
    end
  end

  assign rdata = rdata_r;

endmodule

### src/lhm_pct.sv
// ----------------------------------------------------------------------------
// lhm_pct
// Percentile walk: accumulates bins and finds the 95th/99th percentile bins.
// ----------------------------------------------------------------------------
module lhm_pct #(
  parameter int BIN_WIDTH = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  lhm_pkg::pct_ctl_t    ctl,
  input  logic [63:0]          count,
  input  logic [BIN_WIDTH-1:0] bin,
  output logic [63:0]          p95,
  output logic [63:0]          p99,
  output logic                 done
);

  // 100 * sum of 64 bins of up to 64 bits fits in 77 bits.
  localparam int CW = 77;
  localparam int PW = 71;

  logic [CW-1:0]             cum100_r;
  logic [PW-1:0]             pc95_r;
  logic [PW-1:0]             pc99_r;
  logic                      zero_r;
  logic                      cmp_pend_r;
  logic [lhm_pkg::BIN_AW-1:0] cmp_idx_r;
  logic                      f95_r;
  logic                      f99_r;
  logic [lhm_pkg::BIN_AW-1:0] b95_r;
  logic [lhm_pkg::BIN_AW-1:0] b99_r;
  logic                      done_r;
  logic [CW-1:0]             bin100;
  logic                      hit95;
  logic                      hit99;

  // bin * 100 as shifts
  assign bin100 = (CW'(bin) << 6) + (CW'(bin) << 5) + (CW'(bin) << 2);

  // cum >= ceil(count*p/100) <=> 100*cum >= p*count
  assign hit95 = cmp_pend_r && !f95_r && (cum100_r >= CW'(pc95_r));
  assign hit99 = cmp_pend_r && !f99_r && (cum100_r >= CW'(pc99_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmp_pend_r <= 1'b0;
      f95_r      <= 1'b0;
      f99_r      <= 1'b0;
      done_r     <= 1'b0;
    end else begin
      cmp_pend_r <= ctl.bin_vld;
      if (ctl.start) begin
        f95_r  <= 1'b0;
        f99_r  <= 1'b0;
        done_r <= 1'b0;
      end else if (cmp_pend_r) begin
        if (hit95) begin
          f95_r <= 1'b1;
        end
        if (hit99) begin
          f99_r <= 1'b1;
        end
        if (cmp_idx_r == lhm_pkg::BIN_AW'(lhm_pkg::NUM_BINS - 1)) begin
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      cum100_r <= '0;
      pc95_r   <= PW'(count) * PW'(lhm_pkg::P95);
      pc99_r   <= PW'(count) * PW'(lhm_pkg::P99);
      zero_r   <= (count == 64'd0);
    end else if (ctl.bin_vld) begin
      cum100_r <= cum100_r + bin100;
    end
    cmp_idx_r <= ctl.bin_idx;
    if (hit95) begin
      b95_r <= cmp_idx_r;
    end
    if (hit99) begin
      b99_r <= cmp_idx_r;
    end
  end

  assign p95  = zero_r ? 64'd0 : (f95_r ? lhm_pkg::bin_upper(b95_r) : {64{1'b1}});
  assign p99  = zero_r ? 64'd0 : (f99_r ? lhm_pkg::bin_upper(b99_r) : {64{1'b1}});
  assign done = done_r;

endmodule

### src/latency_log2_histogram_monitor.sv
// ----------------------------------------------------------------------------
// latency_log2_histogram_monitor
// Per-channel latency statistics with log2 histograms and percentile reads.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one item per command. in_tuser = cmd (0 record, 1 snapshot),
//           in_tdata = channel, latency_ns. A record updates count, total,
//           maximum and one log2 bin of its channel while enabled.
//   out_* : one item per snapshot: channel, count, total, maximum, p95, p99.
//           The snapshot also clears the channel.
//   cfg_* : writes the enable bit; always ready.
// Records: a record is a read-modify-write with a read step and a write step,
//   and the next item is taken in the write step, so a new item can enter while
//   a record finishes. An ignored record leaves the block idle and ready.
// Snapshot: a stats read step, a walk over all 64 bins (one memory read per
//   bin, zero written back), a drain (last bin data, compare, done flag), then
//   the output register.
// Reset: a clearing pass writes zero to all CHANNELS*64 histogram entries
//   (and the stats words) with in_tready low throughout.
// Stall: the result waits in the output register; records still flow, and a
//   further snapshot holds in its last step until the register frees.
// ----------------------------------------------------------------------------
module latency_log2_histogram_monitor #(
  parameter int CHANNELS  = 32,
  parameter int BIN_WIDTH = 32
) (
  input  logic         clk,
  input  logic         rst_n,
  // input items
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [71:0]  in_tdata,   // [4:0] channel, [68:5] latency_ns, rest zero
  input  logic         in_tuser,   // [0] cmd
  // result items
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [327:0] out_tdata,  // [4:0] snap_channel, [68:5] snap_count,
                                   // [132:69] snap_total, [196:133] snap_maximum,
                                   // [260:197] snap_p95, [324:261] snap_p99, rest 0
  // configuration
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic         cfg_data    // enabled
);

  localparam int CH_AW  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int HA     = CH_AW + lhm_pkg::BIN_AW;
  localparam int HDEPTH = CHANNELS * lhm_pkg::NUM_BINS;
  localparam int SW     = $bits(lhm_pkg::stat_t);

  typedef enum logic [7:0] {
    ST_CLEAR   = 8'b0000_0001,
    ST_IDLE    = 8'b0000_0010,
    ST_REC_RD  = 8'b0000_0100,
    ST_REC_WR  = 8'b0000_1000,
    ST_SNAP_RD = 8'b0001_0000,
    ST_WALK    = 8'b0010_0000,
    ST_DRAIN   = 8'b0100_0000,
    ST_OUT     = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;

  logic                      en_r;
  logic [4:0]                ch_r;
  logic [63:0]               lat_r;
  logic                      ch_ok_r;
  logic [HA-1:0]             clr_r;
  logic [lhm_pkg::BIN_AW-1:0] walk_r;
  logic                      rd_pend_r;
  logic [lhm_pkg::BIN_AW-1:0] rd_idx_r;
  logic [63:0]               snap_cnt_r;
  logic [63:0]               snap_tot_r;
  logic [63:0]               snap_max_r;
  logic                      out_tvalid_r;
  logic [327:0]              out_tdata_r;

  logic                      accept;
  logic [4:0]                in_ch;
  logic                      in_ch_ok;
  logic [CH_AW-1:0]          ch_addr;
  logic [HA-1:0]             rec_haddr;
  logic                      out_load;

  // memory ports
  logic                      stat_we, stat_re;
  logic [CH_AW-1:0]          stat_waddr, stat_raddr;
  lhm_pkg::stat_t            stat_wdata, stat_q;
  logic [SW-1:0]             stat_q_raw;
  logic                      hist_we, hist_re;
  logic [HA-1:0]             hist_waddr, hist_raddr;
  logic [BIN_WIDTH-1:0]      hist_wdata, hist_q;

  lhm_pkg::pct_ctl_t         pct_ctl;
  logic [63:0]               p95, p99;
  logic                      pct_done;

  assign cfg_ready = 1'b1;

  assign in_tready = (state_r == ST_IDLE) || (state_r == ST_REC_WR);
  assign accept    = in_tvalid && in_tready;
  assign in_ch     = in_tdata[4:0];
  assign in_ch_ok  = (9'(in_ch) < 9'(CHANNELS));
  assign ch_addr   = CH_AW'(ch_r);
  assign rec_haddr = {ch_addr, lhm_pkg::bin_of(lat_r)};
  assign out_load  = (state_r == ST_OUT) && (!out_tvalid_r || out_tready);

  // ---------------------------------------------------------------- sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (clr_r == HA'(HDEPTH - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE, ST_REC_WR: begin
        state_nxt = ST_IDLE;
        if (accept) begin
          if (in_tuser == lhm_pkg::CMD_SNAPSHOT) begin
            state_nxt = in_ch_ok ? ST_SNAP_RD : ST_OUT;
          end else if (en_r && in_ch_ok) begin
            state_nxt = ST_REC_RD;
          end
        end
      end
      ST_REC_RD:  state_nxt = ST_REC_WR;
      ST_SNAP_RD: state_nxt = ST_WALK;
      ST_WALK: begin
        if (walk_r == lhm_pkg::BIN_AW'(lhm_pkg::NUM_BINS - 1)) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (pct_done) begin
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      en_r         <= 1'b0;
      clr_r        <= '0;
      walk_r       <= '0;
      rd_pend_r    <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      rd_pend_r <= (state_r == ST_WALK);
      if (cfg_valid && cfg_ready) begin
        en_r <= cfg_data;
      end
      if (state_r == ST_CLEAR) begin
        clr_r <= clr_r + HA'(1);
      end
      if (state_r == ST_WALK) begin
        walk_r <= walk_r + lhm_pkg::BIN_AW'(1);
      end else begin
        walk_r <= '0;
      end
      if (out_load) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  // item and snapshot payload
  always_ff @(posedge clk) begin
    if (accept) begin
      ch_r    <= in_ch;
      lat_r   <= in_tdata[68:5];
      ch_ok_r <= in_ch_ok;
    end
    rd_idx_r <= walk_r;
    if (pct_ctl.start) begin
      snap_cnt_r <= stat_q.count;
      snap_tot_r <= stat_q.total;
      snap_max_r <= stat_q.maxv;
    end
    if (out_load) begin
      // a channel index of CHANNELS or above reports only its index
      out_tdata_r <= ch_ok_r ? {3'b000, p99, p95, snap_max_r, snap_tot_r, snap_cnt_r, ch_r}
                             : {323'd0, ch_r};
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  // ---------------------------------------------------------- memory access
  always_comb begin
    stat_we    = 1'b0;
    stat_re    = 1'b0;
    stat_waddr = ch_addr;
    stat_raddr = ch_addr;
    stat_wdata = '0;
    hist_we    = 1'b0;
    hist_re    = 1'b0;
    hist_waddr = rec_haddr;
    hist_raddr = rec_haddr;
    hist_wdata = '0;
    case (state_r)
      ST_CLEAR: begin
        stat_we    = 1'b1;
        stat_waddr = clr_r[HA-1:lhm_pkg::BIN_AW];
        hist_we    = 1'b1;
        hist_waddr = clr_r;
      end
      ST_REC_RD: begin
        stat_re = 1'b1;
        hist_re = 1'b1;
      end
      ST_REC_WR: begin
        stat_we          = 1'b1;
        stat_wdata.count = stat_q.count + 64'd1;
        stat_wdata.total = stat_q.total + lat_r;
        stat_wdata.maxv  = (lat_r > stat_q.maxv) ? lat_r : stat_q.maxv;
        hist_we          = 1'b1;
        // bin counters saturate
        hist_wdata       = (hist_q == {BIN_WIDTH{1'b1}}) ? hist_q
                                                         : hist_q + BIN_WIDTH'(1);
      end
      ST_SNAP_RD: begin
        stat_re = 1'b1;
        stat_we = 1'b1;        // read old value, clear in the same cycle
      end
      ST_WALK: begin
        hist_re    = 1'b1;
        hist_we    = 1'b1;
        hist_raddr = {ch_addr, walk_r};
        hist_waddr = {ch_addr, walk_r};
      end
      default: begin
      end
    endcase
  end

  lhm_ram #(
    .WIDTH (SW),
    .DEPTH (CHANNELS),
    .AW    (CH_AW)
  ) u_stat_ram (
    .clk   (clk),
    .we    (stat_we),
    .waddr (stat_waddr),
    .wdata (stat_wdata),
    .re    (stat_re),
    .raddr (stat_raddr),
    .rdata (stat_q_raw)
  );

  assign stat_q = lhm_pkg::stat_t'(stat_q_raw);

  lhm_ram #(
    .WIDTH (BIN_WIDTH),
    .DEPTH (HDEPTH),
    .AW    (HA)
  ) u_hist_ram (
    .clk   (clk),
    .we    (hist_we),
    .waddr (hist_waddr),
    .wdata (hist_wdata),
    .re    (hist_re),
    .raddr (hist_raddr),
    .rdata (hist_q)
  );

  // ------------------------------------------------------- percentile walk
  assign pct_ctl.start   = (state_r == ST_WALK) && (walk_r == '0);
  assign pct_ctl.bin_vld = rd_pend_r;
  assign pct_ctl.bin_idx = rd_idx_r;

  lhm_pct #(
    .BIN_WIDTH (BIN_WIDTH)
  ) u_pct (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (pct_ctl),
    .count (stat_q.count),
    .bin   (hist_q),
    .p95   (p95),
    .p99   (p99),
    .done  (pct_done)
  );

`ifndef SYNTHESIS
  // A result only appears out of the final snapshot step.
  a_out_from_snap: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(state_r == ST_OUT))
    else $error("result raised outside snapshot output step");

  // Read-modify-write on the stats memory stays on one entry.
  a_stat_same_addr: assert property (@(posedge clk) disable iff (!rst_n)
    (stat_we && stat_re) |-> (stat_waddr == stat_raddr))
    else $error("stats read and write at different entries");

  // An enabled record to a valid channel passes a read state, then writes its counters in the write state.
  a_rec_writes: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_tuser == lhm_pkg::CMD_RECORD) && en_r && in_ch_ok)
      |=> ##1 (stat_we && hist_we))
    else $error("record item did not write back");

  // The walk never leaves the drain step before the last bin is compared.
  a_drain_done: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_DRAIN) && (state_nxt == ST_OUT)) |-> (pct_done && !rd_pend_r))
    else $error("snapshot left drain early");
`endif

endmodule

### sim/latency_log2_histogram_monitor_tb.sv
// ----------------------------------------------------------------------------
// latency_log2_histogram_monitor_tb
// Drives record and snapshot items into the latency histogram monitor and
// checks each snapshot against a scoreboard that keeps its own per-channel
// counters, log2 bins and percentile walk, or against a typed expected row.
// A short directed pass comes first, then random phases under both enable
// settings with random idling on both streams, but for one steady phase.
// ----------------------------------------------------------------------------
module latency_log2_histogram_monitor_tb;

  localparam int          CHANNELS   = 32;
  localparam int          BIN_WIDTH  = 32;
  localparam logic [63:0] ONES       = '1;
  localparam int          DRAIN_CYC  = 100;    // longer than the snapshot latency
  localparam int          STALL_MAX  = 20000;  // longer than the reset clearing pass

  // One snapshot result; declaration order lets a typed row use a plain
  // concatenation {channel, count, total, maximum, p95, p99}.
  typedef struct packed {
    logic [4:0]  channel;
    logic [63:0] count;
    logic [63:0] total;
    logic [63:0] maximum;
    logic [63:0] p95;
    logic [63:0] p99;
  } snap_t;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t   kind;
    logic        cfg_val;  // enable value for a ROW_CFG row
    logic        cmd;
    logic [4:0]  ch;
    logic [63:0] lat;
    logic        typed;    // want below is used instead of the scoreboard
    snap_t       want;
  } stim_row_t;

  localparam int DIR_ROWS = 24;

  // Directed pass. Typed rows are the ones readable at a glance: empty
  // channels, a disabled record, single extreme latencies.
  stim_row_t dir_rows [DIR_ROWS] = '{
    // after reset every channel is empty
    '{ROW_ITEM, 1'b0, lhm_pkg::CMD_SNAPSHOT, 5'd0,  64'd0, 1'b1, {5'd0, 320'd0}},
    '{ROW_ITEM, 1'b0, lhm_pkg::CMD_SNAPSHOT, 5'd31, 64'd0, 1'b1, {5'd31, 320'd0}},
    // recording is off after reset: record dropped, snapshot still served
    '{ROW_ITEM, 1'b0, lhm_pkg::CMD_RECORD,   5'd5,  64'd123, 1'b0, '0},
    '{ROW_ITEM, 1'b0, lhm_pkg::CMD_SNAPSHOT, 5'd5,  64'd0, 1'b1, {5'd5, 320'd0}},
    '{ROW_CFG,  1'b1, lhm_pkg::CMD_RECORD,   5'd0,  64'd0, 1'b0, '0},
    // a record of value zero lands in bin 0, upper bound 1
    '{ROW_ITEM, 1'b0, lhm_pkg::CMD_RECORD,   5'd0,  64'd0, 1'b0, '0},
    '{ROW_ITEM, 1'b0, lhm_pkg::CMD_SNAPSHOT, 5'd0,  64'd0, 1'b1,
      {5'd0, 64'd1, 64'd0, 64'd0, 64'd1, 64'd1}},
    // an all-ones record lands in bin 63, reported as all ones
    '{ROW_ITEM, 1'b0, lhm_pkg::CMD_RECORD,   5'd31, ONES, 1'b0, '0},
    '{ROW_ITEM, 1'b0, lhm_pkg::CMD_SNAPSHOT, 5'd31, 64'd0, 1'b1,
      {5'd31, 64'd1, ONES, ONES, ONES, ONES}},
    // spread over low and top bins, total wraps on the last record
    '{ROW_ITEM, 1'b0, lhm_pkg::CMD_RECORD,   5'd1,  64'd1, 1'b0, '0},
    '{ROW_ITEM, 1'b0, lhm_pkg::CMD_RECORD,   5'd1,  64'd2, 1'b0, '0},
    '{ROW_ITEM, 1'b0, lhm_pkg::CMD_RECORD,   5'd1,  64'h8000_0000_0000_0000, 1'b0, '0},
    '{ROW_ITEM, 1'b0, lhm_pkg::CMD_RECORD,   5'd1,  64'h5555_5555_5555_5555, 1'b0, '0},
    '{ROW_ITEM, 1'b0, lhm_pkg::CMD_RECORD,   5'd1,  ONES, 1'b0, '0},
    '{ROW_ITEM, 1'b0, lhm_pkg::CMD_SNAPSHOT, 5'd1,  64'd0, 1'b0, '0},
    '{ROW_ITEM, 1'b0, lhm_pkg::CMD_RECORD,   5'd2,  64'hAAAA_AAAA_AAAA_AAAA, 1'b0, '0},
    '{ROW_ITEM, 1'b0, lhm_pkg::CMD_RECORD,   5'd2,  64'h5555_5555_5555_5555, 1'b0, '0},
    '{ROW_ITEM, 1'b0, lhm_pkg::CMD_RECORD,   5'd2,  64'h0000_0001_0000_0000, 1'b0, '0},
    '{ROW_ITEM, 1'b0, lhm_pkg::CMD_SNAPSHOT, 5'd2,  64'd0, 1'b0, '0},
    // disable again: record ignored
    '{ROW_CFG,  1'b0, lhm_pkg::CMD_RECORD,   5'd0,  64'd0, 1'b0, '0},
    '{ROW_ITEM, 1'b0, lhm_pkg::CMD_RECORD,   5'd3,  64'd7, 1'b0, '0},
    '{ROW_ITEM, 1'b0, lhm_pkg::CMD_SNAPSHOT, 5'd3,  64'd0, 1'b1, {5'd3, 320'd0}},
    '{ROW_CFG,  1'b1, lhm_pkg::CMD_RECORD,   5'd0,  64'd0, 1'b0, '0},
    // a snapshot clears its channel
    '{ROW_ITEM, 1'b0, lhm_pkg::CMD_SNAPSHOT, 5'd2,  64'd0, 1'b1, {5'd2, 320'd0}}
  };

  logic         clk        = 1'b0;
  logic         rst_n      = 1'b0;
  logic         in_tvalid  = 1'b0;
  logic         in_tready;
  logic [71:0]  in_tdata   = '0;   // [4:0] channel, [68:5] latency_ns
  logic         in_tuser   = 1'b0; // [0] cmd
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [327:0] out_tdata;         // [4:0] channel, [68:5] count, [132:69] total,
                                   // [196:133] maximum, [260:197] p95, [324:261] p99
  logic         cfg_valid  = 1'b0;
  logic         cfg_ready;
  logic         cfg_data   = 1'b0; // enabled

  // Scoreboard state: per-channel counters and bins plus the enable bit.
  logic [63:0]          chan_count [CHANNELS];
  logic [63:0]          chan_total [CHANNELS];
  logic [63:0]          chan_max   [CHANNELS];
  logic [BIN_WIDTH-1:0] chan_bins  [CHANNELS][lhm_pkg::NUM_BINS];
  logic                 rec_enabled;

  snap_t       pending_snaps [$];
  int unsigned fail_count  = 0;
  int unsigned stall_cycles = 0;
  bit          steady_run  = 1'b0;  // no idling on either stream

  latency_log2_histogram_monitor #(
    .CHANNELS  (CHANNELS),
    .BIN_WIDTH (BIN_WIDTH)
  ) u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  always #5 clk = ~clk;

  // --------------------------------------------------------------------------
  // Scoreboard
  // --------------------------------------------------------------------------

  // Highest set bit; zero and one both go to bin 0.
  function automatic int log2_bin(input logic [63:0] v);
    int hb;
    hb = 0;
    for (int i = lhm_pkg::NUM_BINS - 1; i > 0; i--) begin
      if (v[i] && hb == 0) begin
        hb = i;
      end
    end
    return hb;
  endfunction

  function automatic logic [63:0] bin_ceiling(input int b);
    if (b >= lhm_pkg::NUM_BINS - 1) begin
      return ONES;
    end
    return (64'd1 << (b + 1)) - 64'd1;
  endfunction

  // Rank = max(1, ceil(count*pct/100)) split into quotient and remainder so
  // the product never overflows; the running sum saturates at all ones.
  function automatic logic [63:0] pct_bound(input int ch, input int pct);
    logic [63:0] cnt;
    logic [63:0] rank;
    logic [63:0] cum;
    cnt = chan_count[ch];
    if (cnt == 0) begin
      return '0;
    end
    rank = (cnt / 100) * pct + ((cnt % 100) * pct + 99) / 100;
    if (rank == 0) begin
      rank = 64'd1;
    end
    cum = '0;
    for (int b = 0; b < lhm_pkg::NUM_BINS; b++) begin
      if (cum > ONES - 64'(chan_bins[ch][b])) begin
        cum = ONES;
      end else begin
        cum += 64'(chan_bins[ch][b]);
      end
      if (cum >= rank) begin
        return bin_ceiling(b);
      end
    end
    return ONES;
  endfunction

  function automatic void record_latency(input int ch, input logic [63:0] lat);
    int b;
    if (!rec_enabled) begin
      return;
    end
    chan_count[ch] += 64'd1;
    chan_total[ch] += lat;
    if (lat > chan_max[ch]) begin
      chan_max[ch] = lat;
    end
    b = log2_bin(lat);
    if (chan_bins[ch][b] != '1) begin
      chan_bins[ch][b] += 1'b1;
    end
  endfunction

  // Report the channel, then clear it.
  function automatic snap_t take_snapshot(input int ch);
    snap_t s;
    s.channel = 5'(ch);
    s.count   = chan_count[ch];
    s.total   = chan_total[ch];
    s.maximum = chan_max[ch];
    s.p95     = pct_bound(ch, lhm_pkg::P95);
    s.p99     = pct_bound(ch, lhm_pkg::P99);
    chan_count[ch] = '0;
    chan_total[ch] = '0;
    chan_max[ch]   = '0;
    for (int b = 0; b < lhm_pkg::NUM_BINS; b++) begin
      chan_bins[ch][b] = '0;
    end
    return s;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus side
  // --------------------------------------------------------------------------

  // Random idle gap, then hold the item until in_tready. in_tvalid is only
  // dropped inside a gap or a wait, so it never toggles within one step.
  task automatic send_item(input logic cmd, input logic [4:0] ch,
                           input logic [63:0] lat, input logic typed,
                           input snap_t want);
    if (!steady_run && $urandom_range(0, 99) < 28) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {3'b000, lat, ch};
    do @(posedge clk); while (!in_tready);
    if (cmd == lhm_pkg::CMD_SNAPSHOT) begin
      if (typed) begin
        void'(take_snapshot(ch));
        pending_snaps.push_back(want);
      end else begin
        pending_snaps.push_back(take_snapshot(ch));
      end
    end else begin
      record_latency(ch, lat);
    end
  endtask

  // Wait for every outstanding snapshot, then let a record or a snapshot
  // still in the pipe settle before touching the enable bit.
  task automatic drain_all();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending_snaps.size() != 0);
    repeat (DRAIN_CYC) @(posedge clk);
  endtask

  task automatic write_enable(input logic v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    rec_enabled = v;
    cfg_valid <= 1'b0;
  endtask

  // Spread latencies over all 64 bins, with the odd zero or all-ones value.
  function automatic logic [63:0] rand_latency();
    logic [63:0] v;
    int          k;
    k = $urandom_range(0, 63);
    v = {$urandom, $urandom};
    case ($urandom_range(0, 19))
      0:       return '0;
      1:       return ONES;
      default: return v >> (63 - k);
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  localparam int PHASES = 4;
  // enable per phase, item count per phase; phase 2 runs without idling
  localparam logic    PHASE_EN  [PHASES] = '{1'b1, 1'b0, 1'b1, 1'b1};
  localparam int      PHASE_LEN [PHASES] = '{320, 80, 340, 340};

  initial begin
    logic [4:0] ch;
    logic       cmd;

    for (int c = 0; c < CHANNELS; c++) begin
      chan_count[c] = '0;
      chan_total[c] = '0;
      chan_max[c]   = '0;
      for (int b = 0; b < lhm_pkg::NUM_BINS; b++) begin
        chan_bins[c][b] = '0;
      end
    end
    rec_enabled = 1'b0;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // directed pass
    for (int i = 0; i < DIR_ROWS; i++) begin
      if (dir_rows[i].kind == ROW_CFG) begin
        drain_all();
        write_enable(dir_rows[i].cfg_val);
      end else begin
        send_item(dir_rows[i].cmd, dir_rows[i].ch, dir_rows[i].lat,
                  dir_rows[i].typed, dir_rows[i].want);
      end
    end

    // random phases
    for (int p = 0; p < PHASES; p++) begin
      drain_all();
      write_enable(PHASE_EN[p]);
      steady_run = (p == 2);
      for (int n = 0; n < PHASE_LEN[p]; n++) begin
        // mostly a few hot channels so counts grow and percentiles move
        ch  = ($urandom_range(0, 3) != 0) ? 5'($urandom_range(0, 3))
                                          : 5'($urandom_range(0, CHANNELS - 1));
        cmd = ($urandom_range(0, 99) < 6) ? lhm_pkg::CMD_SNAPSHOT : lhm_pkg::CMD_RECORD;
        // sender holds off until the result side has caught up
        if ($urandom_range(0, 99) == 0) begin
          in_tvalid <= 1'b0;
          do @(posedge clk); while (pending_snaps.size() != 0);
        end
        send_item(cmd, ch, rand_latency(), 1'b0, '0);
      end
    end

    // flush every channel so all state is seen once more
    steady_run = 1'b0;
    for (int c = 0; c < CHANNELS; c++) begin
      send_item(lhm_pkg::CMD_SNAPSHOT, 5'(c), 64'd0, 1'b0, '0);
    end

    drain_all();
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // --------------------------------------------------------------------------
  // Result side: random back-pressure, compare, watchdog
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    out_tready <= steady_run || ($urandom_range(0, 99) >= 28);
  end

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] seen);
    if (want !== seen) begin
      $error("%s: expected %0h, got %0h", name, want, seen);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    snap_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_snaps.size() == 0) begin
        $error("result item with nothing pending, channel %0d", out_tdata[4:0]);
        fail_count++;
      end else begin
        want = pending_snaps.pop_front();
        check_field("snap_channel", 64'(want.channel), 64'(out_tdata[4:0]));
        check_field("snap_count",   want.count,   out_tdata[68:5]);
        check_field("snap_total",   want.total,   out_tdata[132:69]);
        check_field("snap_maximum", want.maximum, out_tdata[196:133]);
        check_field("snap_p95",     want.p95,     out_tdata[260:197]);
        check_field("snap_p99",     want.p99,     out_tdata[324:261]);
      end
    end

    // no item moving on any channel for too long means the block is stuck
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_MAX) begin
      $display("simulation failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

endmodule

### sim.f
src/lhm_pkg.sv
src/lhm_ram.sv
src/lhm_pct.sv
src/latency_log2_histogram_monitor.sv
sim/latency_log2_histogram_monitor_tb.sv
